// ----- hw/rtl/raycast_column_ray_setup_top_assert.svh -----
// Assertion macros for the raycast column ray setup block
`ifndef RAYCAST_COLUMN_RAY_SETUP_TOP_ASSERT_SVH
`define RAYCAST_COLUMN_RAY_SETUP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define RCS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcs assertion failed");
`define RCS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcs assertion failed");
`else
`define RCS_ASSERT(label, ante, cons)
`define RCS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/rcs_pkg.sv -----
// Types and constants shared by the ray setup block
`timescale 1ns / 1ps
package rcs_pkg;
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 24;
  localparam int DIR_W     = 20;
  localparam int RAY_W     = 22;
  localparam int DIST_W    = 24;
  localparam int CELL_W    = 8;
  localparam int COL_W     = 10;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int SQ_W      = 2 * RAY_W;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_POS_X   = 3'd0,
    CFG_CAM_POS_Y   = 3'd1,
    CFG_VIEW_DIR_X  = 3'd2,
    CFG_VIEW_DIR_Y  = 3'd3,
    CFG_CAM_PLANE_X = 3'd4,
    CFG_CAM_PLANE_Y = 3'd5
  } cfg_idx_t;
endpackage

// ----- hw/rtl/rcs_if.sv -----
// Input and result channel interfaces
`timescale 1ns / 1ps
interface rcs_in_if;
  logic                     valid;
  logic                     ready;
  logic [rcs_pkg::COL_W-1:0] column;
  modport source (output valid, output column, input ready);
  modport sink (input valid, input column, output ready);
endinterface

interface rcs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rcs_pkg::RAY_W-1:0] ray_dir_x;
  logic signed [rcs_pkg::RAY_W-1:0] ray_dir_y;
  logic [rcs_pkg::CELL_W-1:0]       cell_x;
  logic [rcs_pkg::CELL_W-1:0]       cell_y;
  logic [rcs_pkg::DIST_W-1:0]       delta_x;
  logic [rcs_pkg::DIST_W-1:0]       delta_y;
  logic                             step_x_neg;
  logic                             step_y_neg;
  logic [rcs_pkg::DIST_W-1:0]       side_x;
  logic [rcs_pkg::DIST_W-1:0]       side_y;
  modport source (output valid, output ray_dir_x, output ray_dir_y, output cell_x,
                  output cell_y, output delta_x, output delta_y, output step_x_neg,
                  output step_y_neg, output side_x, output side_y, input ready);
  modport sink (input valid, input ray_dir_x, input ray_dir_y, input cell_x,
                input cell_y, input delta_x, input delta_y, input step_x_neg,
                input step_y_neg, input side_x, input side_y, output ready);
endinterface

// ----- hw/rtl/rcs_div_cell.sv -----
// One restoring division step for an x and a y lane
`timescale 1ns / 1ps
module rcs_div_cell #(
  parameter int DW = 13,
  parameter int NW = 32,
  parameter int QW = 32,
  parameter int PW = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [1:0][DW-1:0]  in_rem,
  input  logic [1:0][NW-1:0]  in_num,
  input  logic [1:0][QW-1:0]  in_quo,
  input  logic [1:0][DW-1:0]  in_div,
  input  logic [PW-1:0]       in_pay,
  output logic                out_valid,
  output logic [1:0][DW-1:0]  out_rem,
  output logic [1:0][NW-1:0]  out_num,
  output logic [1:0][QW-1:0]  out_quo,
  output logic [1:0][DW-1:0]  out_div,
  output logic [PW-1:0]       out_pay
);
  logic              valid_r;
  logic [1:0][DW-1:0] rem_r, rem_nxt, div_r;
  logic [1:0][NW-1:0] num_r, num_nxt;
  logic [1:0][QW-1:0] quo_r, quo_nxt;
  logic [PW-1:0]     pay_r;

  always_comb begin
    logic [DW:0] sh;
    logic [DW:0] dv;
    logic        ge;
    for (int l = 0; l < 2; l++) begin
      sh         = {in_rem[l], in_num[l][NW-1]};
      dv         = {1'b0, in_div[l]};
      ge         = (sh >= dv);
      rem_nxt[l] = ge ? DW'(sh - dv) : sh[DW-1:0];
      num_nxt[l] = in_num[l] << 1;
      quo_nxt[l] = {in_quo[l][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      div_r <= in_div;
      pay_r <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_num   = num_r;
  assign out_quo   = quo_r;
  assign out_div   = div_r;
  assign out_pay   = pay_r;
endmodule

// ----- hw/rtl/rcs_sqrt_cell.sv -----
// One digit step of an integer square root
`timescale 1ns / 1ps
module rcs_sqrt_cell #(
  parameter int QW = 22,
  parameter int PW = 44
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [QW+1:0]     in_rem,
  input  logic [2*QW-1:0]   in_num,
  input  logic [QW-1:0]     in_root,
  input  logic [PW-1:0]     in_pay,
  output logic              out_valid,
  output logic [QW+1:0]     out_rem,
  output logic [2*QW-1:0]   out_num,
  output logic [QW-1:0]     out_root,
  output logic [PW-1:0]     out_pay
);
  logic            valid_r;
  logic [QW+1:0]   rem_r, rem_nxt;
  logic [2*QW-1:0] num_r;
  logic [QW-1:0]   root_r, root_nxt;
  logic [PW-1:0]   pay_r;

  always_comb begin
    logic [QW+3:0] sh;
    logic [QW+3:0] t;
    logic          ge;
    sh       = {in_rem, in_num[2*QW-1:2*QW-2]};
    t        = {2'b00, in_root, 2'b01};
    ge       = (sh >= t);
    rem_nxt  = ge ? (QW+2)'(sh - t) : sh[QW+1:0];
    root_nxt = {in_root[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      num_r  <= in_num << 2;
      root_r <= root_nxt;
      pay_r  <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_num   = num_r;
  assign out_root  = root_r;
  assign out_pay   = pay_r;
endmodule

// ----- hw/rtl/raycast_column_ray_setup_top.sv -----
// Ray setup for a grid raycaster: column index in, DDA start state out.
// Takes one column per cycle while results are taken and delivers one result
// per column, in order. A reciprocal multiply split over two stages scales the
// camera plane by 1/SCREEN_WIDTH, RAY_W square-root cells give the ray length,
// and DIST_W division cells give the delta distances, each cell settling one
// result bit. The whole chain holds while a finished result is not taken.
// Write configuration only while no item is in flight.
`timescale 1ns / 1ps
`include "raycast_column_ray_setup_top_assert.svh"
module raycast_column_ray_setup_top #(
  parameter int SCREEN_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcs_pkg::CFG_W-1:0]   cfg_data,
  rcs_in_if.sink                      in_ch,
  rcs_out_if.source                   out_ch
);
  localparam int F      = rcs_pkg::FRAC_BITS;
  localparam int RAY_W  = rcs_pkg::RAY_W;
  localparam int DIR_W  = rcs_pkg::DIR_W;
  localparam int DIST_W = rcs_pkg::DIST_W;
  localparam int POS_W  = rcs_pkg::POS_W;
  localparam int SQ_W   = rcs_pkg::SQ_W;
  localparam int NUM_W  = $clog2((SCREEN_WIDTH > 2046) ? SCREEN_WIDTH : 2046) + 2;
  localparam int PROD_W = DIR_W + NUM_W;
  localparam int NW_W   = DIR_W + NUM_W - 1;
  localparam int SUM_W  = NW_W + 2;
  localparam int SHR    = DIST_W - F;
  localparam int RSH    = NW_W + $clog2(SCREEN_WIDTH);
  localparam int RLO_W  = 16;
  localparam int PRD_W  = 2 * NW_W + 1;
  localparam logic [NW_W:0] RECIP =
    (NW_W+1)'(((64'd1 << RSH) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));
  localparam logic signed [SUM_W-1:0] RAY_HI = SUM_W'((2 ** (RAY_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] RAY_LO = -SUM_W'(2 ** (RAY_W - 1));

  logic [POS_W-1:0]        cam_pos_x_r, cam_pos_y_r;
  logic signed [DIR_W-1:0] view_dir_x_r, view_dir_y_r, cam_plane_x_r, cam_plane_y_r;
  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_pos_x_r   <= '0;
      cam_pos_y_r   <= '0;
      view_dir_x_r  <= DIR_W'(65536);
      view_dir_y_r  <= '0;
      cam_plane_x_r <= '0;
      cam_plane_y_r <= DIR_W'(43254);
    end else if (cfg_we) begin
      case (cfg_index)
        rcs_pkg::CFG_CAM_POS_X:   cam_pos_x_r   <= cfg_data[POS_W-1:0];
        rcs_pkg::CFG_CAM_POS_Y:   cam_pos_y_r   <= cfg_data[POS_W-1:0];
        rcs_pkg::CFG_VIEW_DIR_X:  view_dir_x_r  <= cfg_data[DIR_W-1:0];
        rcs_pkg::CFG_VIEW_DIR_Y:  view_dir_y_r  <= cfg_data[DIR_W-1:0];
        rcs_pkg::CFG_CAM_PLANE_X: cam_plane_x_r <= cfg_data[DIR_W-1:0];
        rcs_pkg::CFG_CAM_PLANE_Y: cam_plane_y_r <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // scale plane by column offset
  logic                    s1_valid_r;
  logic [1:0]              s1_neg_r;
  logic [1:0][NW_W-1:0]    s1_num_r;
  logic signed [NUM_W-1:0] col_off;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic [PROD_W-1:0]       mag_x, mag_y;

  always_comb begin
    col_off = $signed({{(NUM_W - rcs_pkg::COL_W - 1){1'b0}}, in_ch.column, 1'b0})
              - NUM_W'(SCREEN_WIDTH);
    prod_x  = PROD_W'(cam_plane_x_r) * PROD_W'(col_off);
    prod_y  = PROD_W'(cam_plane_y_r) * PROD_W'(col_off);
    mag_x   = prod_x[PROD_W-1] ? PROD_W'(-prod_x) : PROD_W'(prod_x);
    mag_y   = prod_y[PROD_W-1] ? PROD_W'(-prod_y) : PROD_W'(prod_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg_r    <= {prod_y[PROD_W-1], prod_x[PROD_W-1]};
      s1_num_r[0] <= NW_W'(mag_x) + NW_W'(SCREEN_WIDTH / 2);
      s1_num_r[1] <= NW_W'(mag_y) + NW_W'(SCREEN_WIDTH / 2);
    end
  end

  // divide by screen width: multiply by the reciprocal in two halves, then sum
  logic                         md_valid_r, qt_valid_r;
  logic [1:0]                   md_neg_r, qt_neg_r;
  logic [1:0][NW_W+RLO_W-1:0]   md_lo_r;
  logic [1:0][PRD_W-RLO_W-1:0]  md_hi_r;
  logic [1:0][NW_W-1:0]         qt_quo_r;
  logic [1:0][PRD_W-1:0]        prd;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prd[l] = {md_hi_r[l], {RLO_W{1'b0}}} + PRD_W'(md_lo_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_valid_r <= 1'b0;
      qt_valid_r <= 1'b0;
    end else if (en) begin
      md_valid_r <= s1_valid_r;
      qt_valid_r <= md_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_neg_r <= s1_neg_r;
      qt_neg_r <= md_neg_r;
      for (int l = 0; l < 2; l++) begin
        md_lo_r[l]  <= (NW_W+RLO_W)'(s1_num_r[l]) * (NW_W+RLO_W)'(RECIP[RLO_W-1:0]);
        md_hi_r[l]  <= (PRD_W-RLO_W)'(s1_num_r[l]) * (PRD_W-RLO_W)'(RECIP[NW_W:RLO_W]);
        qt_quo_r[l] <= NW_W'(prd[l] >> RSH);
      end
    end
  end

  // add view direction and saturate
  function automatic logic signed [RAY_W-1:0] ray_sat(input logic signed [DIR_W-1:0] dir,
                                                     input logic neg,
                                                     input logic [NW_W-1:0] q);
    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] sum;
    qs  = $signed({2'b00, q});
    sum = SUM_W'(dir) + (neg ? -qs : qs);
    if (sum > RAY_HI) begin
      sum = RAY_HI;
    end else if (sum < RAY_LO) begin
      sum = RAY_LO;
    end
    return sum[RAY_W-1:0];
  endfunction

  logic                    s2_valid_r;
  logic signed [RAY_W-1:0] s2_rx_r, s2_ry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= qt_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rx_r <= ray_sat(view_dir_x_r, qt_neg_r[0], qt_quo_r[0]);
      s2_ry_r <= ray_sat(view_dir_y_r, qt_neg_r[1], qt_quo_r[1]);
    end
  end

  // square and sum
  logic                    s3_valid_r, s4_valid_r;
  logic signed [RAY_W-1:0] s3_rx_r, s3_ry_r, s4_rx_r, s4_ry_r;
  logic signed [SQ_W-1:0]  sq_x, sq_y;
  logic [SQ_W-1:0]         s3_sqx_r, s3_sqy_r, s4_sum_r;

  assign sq_x = SQ_W'(s2_rx_r) * SQ_W'(s2_rx_r);
  assign sq_y = SQ_W'(s2_ry_r) * SQ_W'(s2_ry_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sqx_r <= unsigned'(sq_x);
      s3_sqy_r <= unsigned'(sq_y);
      s3_rx_r  <= s2_rx_r;
      s3_ry_r  <= s2_ry_r;
      s4_sum_r <= s3_sqx_r + s3_sqy_r;
      s4_rx_r  <= s3_rx_r;
      s4_ry_r  <= s3_ry_r;
    end
  end

  // ray length
  logic                  sq_valid [0:RAY_W];
  logic [RAY_W+1:0]      sq_rem   [0:RAY_W];
  logic [SQ_W-1:0]       sq_num   [0:RAY_W];
  logic [RAY_W-1:0]      sq_root  [0:RAY_W];
  logic [2*RAY_W-1:0]    sq_pay   [0:RAY_W];

  assign sq_valid[0] = s4_valid_r;
  assign sq_rem[0]   = '0;
  assign sq_num[0]   = s4_sum_r;
  assign sq_root[0]  = '0;
  assign sq_pay[0]   = {s4_ry_r, s4_rx_r};

  for (genvar i = 0; i < RAY_W; i++) begin : g_sqrt
    rcs_sqrt_cell #(.QW(RAY_W), .PW(2 * RAY_W)) u_cell (
      .clk, .rst_n, .en,
      .in_valid(sq_valid[i]), .in_rem(sq_rem[i]), .in_num(sq_num[i]),
      .in_root(sq_root[i]), .in_pay(sq_pay[i]),
      .out_valid(sq_valid[i+1]), .out_rem(sq_rem[i+1]), .out_num(sq_num[i+1]),
      .out_root(sq_root[i+1]), .out_pay(sq_pay[i+1])
    );
  end

  // set up delta division, flag overflow and zero components
  logic                    s5_valid_r;
  logic [1:0][RAY_W-1:0]   s5_rem_r, s5_div_r;
  logic [1:0][DIST_W-1:0]  s5_num_r;
  logic [2*RAY_W+1:0]      s5_pay_r;
  logic [RAY_W-1:0]        len;
  logic [1:0][RAY_W-1:0]   cmag;
  logic [1:0]              dsat;

  always_comb begin
    logic signed [RAY_W-1:0] c;
    len = sq_root[RAY_W];
    for (int l = 0; l < 2; l++) begin
      c       = sq_pay[RAY_W][l*RAY_W +: RAY_W];
      cmag[l] = c[RAY_W-1] ? RAY_W'(-c) : RAY_W'(c);
      dsat[l] = ({{SHR{1'b0}}, len} >= {cmag[l], {SHR{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= sq_valid[RAY_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        s5_rem_r[l] <= RAY_W'(len >> SHR);
        s5_num_r[l] <= {len[SHR-1:0], {F{1'b0}}};
        s5_div_r[l] <= cmag[l];
      end
      s5_pay_r <= {dsat, sq_pay[RAY_W]};
    end
  end

  // delta distances
  logic                     dd_valid [0:DIST_W];
  logic [1:0][RAY_W-1:0]    dd_rem   [0:DIST_W];
  logic [1:0][DIST_W-1:0]   dd_num   [0:DIST_W];
  logic [1:0][DIST_W-1:0]   dd_quo   [0:DIST_W];
  logic [1:0][RAY_W-1:0]    dd_div   [0:DIST_W];
  logic [2*RAY_W+1:0]       dd_pay   [0:DIST_W];

  assign dd_valid[0] = s5_valid_r;
  assign dd_rem[0]   = s5_rem_r;
  assign dd_num[0]   = s5_num_r;
  assign dd_quo[0]   = '0;
  assign dd_div[0]   = s5_div_r;
  assign dd_pay[0]   = s5_pay_r;

  for (genvar i = 0; i < DIST_W; i++) begin : g_ddiv
    rcs_div_cell #(.DW(RAY_W), .NW(DIST_W), .QW(DIST_W), .PW(2 * RAY_W + 2)) u_cell (
      .clk, .rst_n, .en,
      .in_valid(dd_valid[i]), .in_rem(dd_rem[i]), .in_num(dd_num[i]),
      .in_quo(dd_quo[i]), .in_div(dd_div[i]), .in_pay(dd_pay[i]),
      .out_valid(dd_valid[i+1]), .out_rem(dd_rem[i+1]), .out_num(dd_num[i+1]),
      .out_quo(dd_quo[i+1]), .out_div(dd_div[i+1]), .out_pay(dd_pay[i+1])
    );
  end

  // side distances and result register
  logic signed [RAY_W-1:0] fin_rx, fin_ry;
  logic [DIST_W-1:0]       fin_dx, fin_dy, fin_sx, fin_sy;

  function automatic logic [DIST_W-1:0] side_of(input logic [POS_W-1:0] pos,
                                               input logic neg,
                                               input logic [DIST_W-1:0] delta);
    logic [F:0]          span;
    logic [F+DIST_W:0]   p;
    logic [DIST_W:0]     s;
    span = neg ? {1'b0, pos[F-1:0]} : ((F+1)'(1) << F) - {1'b0, pos[F-1:0]};
    p    = (F+DIST_W+1)'(span) * (F+DIST_W+1)'(delta);
    s    = p[F+DIST_W:F];
    return s[DIST_W] ? rcs_pkg::DIST_MAX : s[DIST_W-1:0];
  endfunction

  always_comb begin
    fin_rx = dd_pay[DIST_W][RAY_W-1:0];
    fin_ry = dd_pay[DIST_W][2*RAY_W-1:RAY_W];
    fin_dx = dd_pay[DIST_W][2*RAY_W]   ? rcs_pkg::DIST_MAX : dd_quo[DIST_W][0];
    fin_dy = dd_pay[DIST_W][2*RAY_W+1] ? rcs_pkg::DIST_MAX : dd_quo[DIST_W][1];
    fin_sx = side_of(cam_pos_x_r, fin_rx[RAY_W-1], fin_dx);
    fin_sy = side_of(cam_pos_y_r, fin_ry[RAY_W-1], fin_dy);
  end

  logic signed [RAY_W-1:0] out_rx_r, out_ry_r;
  logic [DIST_W-1:0]       out_dx_r, out_dy_r, out_sx_r, out_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dd_valid[DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rx_r <= fin_rx;
      out_ry_r <= fin_ry;
      out_dx_r <= fin_dx;
      out_dy_r <= fin_dy;
      out_sx_r <= fin_sx;
      out_sy_r <= fin_sy;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ray_dir_x  = out_rx_r;
  assign out_ch.ray_dir_y  = out_ry_r;
  assign out_ch.cell_x     = cam_pos_x_r[F +: rcs_pkg::CELL_W];
  assign out_ch.cell_y     = cam_pos_y_r[F +: rcs_pkg::CELL_W];
  assign out_ch.delta_x    = out_dx_r;
  assign out_ch.delta_y    = out_dy_r;
  assign out_ch.step_x_neg = out_rx_r[RAY_W-1];
  assign out_ch.step_y_neg = out_ry_r[RAY_W-1];
  assign out_ch.side_x     = out_sx_r;
  assign out_ch.side_y     = out_sy_r;

  `RCS_ASSERT(a_zero_dx, out_valid_r && (out_rx_r == '0), out_dx_r == rcs_pkg::DIST_MAX)
  `RCS_ASSERT(a_side_le_delta, out_valid_r, (out_sx_r <= out_dx_r) && (out_sy_r <= out_dy_r))
  `RCS_ASSERT_NXT(a_stall_hold, !en && s5_valid_r, s5_valid_r)
endmodule

// ----- tb/sv/tb_rcs_if.sv -----
// Result record type for the ray setup testbench build
`timescale 1ns / 1ps
// The block's interfaces come from the RTL file list; this file only groups the testbench types.
package tb_rcs_types;
  typedef struct {
    logic signed [21:0] ray_dir_x;
    logic signed [21:0] ray_dir_y;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
    logic [23:0]        delta_x;
    logic [23:0]        delta_y;
    logic               step_x_neg;
    logic               step_y_neg;
    logic [23:0]        side_x;
    logic [23:0]        side_y;
  } ray_start_t;
endpackage

// ----- tb/sv/tb_top.sv -----
// Testbench for the column ray setup block: directed table plus random columns and cameras
`timescale 1ns / 1ps
module tb_top;
  localparam int WIDTH = 1024;
  localparam int LAT = 4 + 10 + rcs_pkg::RAY_W + rcs_pkg::DIST_W;
  localparam longint LIMIT = 4000000;

  logic clk, rst_n, cfg_we;
  logic [rcs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rcs_pkg::CFG_W-1:0] cfg_data;
  rcs_in_if in_ch();
  rcs_out_if out_ch();

  raycast_column_ray_setup_top DUT (.clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch));

  logic [23:0] pos_x, pos_y;
  logic signed [19:0] dir_x, dir_y, plane_x, plane_y;
  tb_rcs_types::ray_start_t pending_rays[$];
  int errors, sent, got;
  longint cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint scaled_ray(longint d, longint p, longint num);
    longint prod, mag, q, r;
    prod = p * num;
    mag = prod < 0 ? -prod : prod;
    q = (mag + WIDTH / 2) / WIDTH;
    r = d + (prod < 0 ? -q : q);
    if (r > 2097151) r = 2097151;
    if (r < -2097152) r = -2097152;
    return r;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic [23:0] grid_delta(longint len, longint comp);
    longint mag, d;
    mag = comp < 0 ? -comp : comp;
    if (mag == 0) return rcs_pkg::DIST_MAX;
    d = (len << rcs_pkg::FRAC_BITS) / mag;
    return d > 64'hFFFFFF ? rcs_pkg::DIST_MAX : d[23:0];
  endfunction

  function automatic logic [23:0] first_side(logic [23:0] pos, logic neg, logic [23:0] dl);
    longint frac, s;
    frac = pos[15:0];
    s = ((neg ? frac : 65536 - frac) * longint'(dl)) >> rcs_pkg::FRAC_BITS;
    return s > 64'hFFFFFF ? rcs_pkg::DIST_MAX : s[23:0];
  endfunction

  function automatic tb_rcs_types::ray_start_t ray_for_column(logic [9:0] col);
    tb_rcs_types::ray_start_t r;
    longint num, rx, ry, len;
    num = 2 * longint'(col) - WIDTH;
    rx = scaled_ray(dir_x, plane_x, num);
    ry = scaled_ray(dir_y, plane_y, num);
    len = int_sqrt(rx * rx + ry * ry);
    r.ray_dir_x = rx[21:0];
    r.ray_dir_y = ry[21:0];
    r.cell_x = pos_x[23:16];
    r.cell_y = pos_y[23:16];
    r.delta_x = grid_delta(len, rx);
    r.delta_y = grid_delta(len, ry);
    r.step_x_neg = rx < 0;
    r.step_y_neg = ry < 0;
    r.side_x = first_side(pos_x, r.step_x_neg, r.delta_x);
    r.side_y = first_side(pos_y, r.step_y_neg, r.delta_y);
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(rcs_pkg::cfg_idx_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      rcs_pkg::CFG_CAM_POS_X: pos_x = val;
      rcs_pkg::CFG_CAM_POS_Y: pos_y = val;
      rcs_pkg::CFG_VIEW_DIR_X: dir_x = val[19:0];
      rcs_pkg::CFG_VIEW_DIR_Y: dir_y = val[19:0];
      rcs_pkg::CFG_CAM_PLANE_X: plane_x = val[19:0];
      default: plane_y = val[19:0];
    endcase
  endtask

  task automatic drain();
    while (pending_rays.size() != 0) @(negedge clk);
    repeat (LAT + 8) @(negedge clk);
  endtask

  task automatic send_column(logic [9:0] col, bit use_gaps);
    int g;
    g = use_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.column <= col;
    pending_rays.push_back(ray_for_column(col));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic report(string name, longint e, longint a);
    if (e != a) begin
      $error("%s expected %0h got %0h", name, e, a);
      errors++;
    end
  endtask

  bit rx_stall;
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else if (rx_stall) out_ch.ready <= ($urandom_range(0, 9) < 6);
    else out_ch.ready <= 1;
  end

  always @(posedge clk) begin
    tb_rcs_types::ray_start_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got++;
      if (pending_rays.size() == 0) begin
        $error("result with no expectation");
        errors++;
      end else begin
        e = pending_rays.pop_front();
        report("ray_dir_x", e.ray_dir_x, out_ch.ray_dir_x);
        report("ray_dir_y", e.ray_dir_y, out_ch.ray_dir_y);
        report("cell_x", e.cell_x, out_ch.cell_x);
        report("cell_y", e.cell_y, out_ch.cell_y);
        report("delta_x", e.delta_x, out_ch.delta_x);
        report("delta_y", e.delta_y, out_ch.delta_y);
        report("step_x_neg", e.step_x_neg, out_ch.step_x_neg);
        report("step_y_neg", e.step_y_neg, out_ch.step_y_neg);
        report("side_x", e.side_x, out_ch.side_x);
        report("side_y", e.side_y, out_ch.side_y);
      end
    end
  end

  typedef struct {
    logic [9:0]  col;
    bit          known;
    logic [23:0] dx, dy;
  } column_row_t;

  column_row_t dir_table[] = '{
    '{10'd512, 1, 24'h010000, rcs_pkg::DIST_MAX},
    '{10'd0, 0, 0, 0}, '{10'd1023, 0, 0, 0}, '{10'd1, 0, 0, 0},
    '{10'd256, 0, 0, 0}, '{10'd768, 0, 0, 0}, '{10'd511, 0, 0, 0},
    '{10'd513, 0, 0, 0}, '{10'h2AA, 0, 0, 0}, '{10'h155, 0, 0, 0}
  };

  initial begin
    logic [9:0] c;
    cycles = 0; errors = 0; sent = 0; got = 0;
    rst_n = 0; cfg_we = 0; cfg_index = rcs_pkg::CFG_CAM_POS_X; cfg_data = '0;
    in_ch.valid = 0; in_ch.column = '0; rx_stall = 0;
    pos_x = 0; pos_y = 0; dir_x = 20'sd65536; dir_y = 0; plane_x = 0; plane_y = 20'sd43254;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // reset camera: column 512 looks straight along x
    foreach (dir_table[i]) begin
      send_column(dir_table[i].col, 0);
      if (dir_table[i].known) begin
        report("table delta_x", dir_table[i].dx, pending_rays[pending_rays.size()-1].delta_x);
        report("table delta_y", dir_table[i].dy, pending_rays[pending_rays.size()-1].delta_y);
      end
    end
    in_ch.valid <= 0;
    drain();

    // extreme cameras, including zero direction and upper register bits
    write_reg(rcs_pkg::CFG_CAM_POS_X, 24'hFFFFFF);
    write_reg(rcs_pkg::CFG_CAM_POS_Y, 24'h000000);
    write_reg(rcs_pkg::CFG_VIEW_DIR_X, 24'hF7FFFF);
    write_reg(rcs_pkg::CFG_VIEW_DIR_Y, 24'h080000);
    write_reg(rcs_pkg::CFG_CAM_PLANE_X, 24'h080000);
    write_reg(rcs_pkg::CFG_CAM_PLANE_Y, 24'h07FFFF);
    foreach (dir_table[i]) send_column(dir_table[i].col, 0);
    in_ch.valid <= 0;
    drain();
    write_reg(rcs_pkg::CFG_VIEW_DIR_X, 24'h0);
    write_reg(rcs_pkg::CFG_VIEW_DIR_Y, 24'h0);
    write_reg(rcs_pkg::CFG_CAM_PLANE_X, 24'h0);
    write_reg(rcs_pkg::CFG_CAM_PLANE_Y, 24'h0);
    send_column(10'd0, 0);
    send_column(10'd1023, 0);
    in_ch.valid <= 0;
    drain();

    rx_stall = 1;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(rcs_pkg::CFG_CAM_POS_X, 24'($urandom));
      write_reg(rcs_pkg::CFG_CAM_POS_Y, 24'($urandom));
      write_reg(rcs_pkg::CFG_VIEW_DIR_X,
                24'(ph % 3 == 0 ? $urandom : $urandom_range(0, 131072) - 65536));
      write_reg(rcs_pkg::CFG_VIEW_DIR_Y,
                24'(ph % 3 == 0 ? $urandom : $urandom_range(0, 131072) - 65536));
      write_reg(rcs_pkg::CFG_CAM_PLANE_X,
                24'(ph % 3 == 1 ? $urandom : $urandom_range(0, 87000) - 43500));
      write_reg(rcs_pkg::CFG_CAM_PLANE_Y,
                24'(ph % 3 == 1 ? $urandom : $urandom_range(0, 87000) - 43500));
      rx_stall = (ph % 4 != 3);
      for (int k = 0; k < 100; k++) begin
        c = 10'($urandom);
        send_column(c, ph % 4 != 3);
        if (k == 50) begin
          in_ch.valid <= 0;
          while (pending_rays.size() != 0) @(negedge clk);
        end
      end
      in_ch.valid <= 0;
      drain();
    end

    $display("Ran %0d columns through %0d camera settings, extremes and random.", sent, 15);
    $display("Checked %0d ray setup results field by field.", got);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
